// ----- design/bat_pkg.sv -----
package bat_pkg;

   localparam int BAT_LEVELS          = 10;
   localparam int BAT_MIN_BLOCK_POWER = 4;

   // width of the size class a request needs, covers any 16-bit request
   localparam int NEED_W = 6;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_SPACE = 2'd1,
      STATUS_BAD_PTR  = 2'd2
   } status_type;

   typedef struct packed {
      logic        op;
      logic [15:0] request_bytes;
      logic [15:0] free_offset;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [12:0] block_offset;
      logic [3:0]  block_class;
      logic [3:0]  largest_free_class;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_DESC,
      ST_WALK,
      ST_MARK,
      ST_UP,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic       clr_write;
      logic       take;
      logic       fail;
      status_type fail_code;
      logic       read_kids;
      logic       descend;
      logic       walk_up;
      logic       mark;
      logic       up;
      logic       load_out;
   } bat_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic req_free;
      logic req_bad;
      logic root_fits;
      logic kid_fits;
      logic kids_leaf;
      logic node_free;
      logic node_right;
      logic at_root;
      logic parent_root;
      logic out_free;
   } bat_sts_type;

endpackage

// ----- design/bat_ctrl.sv -----
module bat_ctrl
   import bat_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  bat_sts_type sts,
   output bat_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (!sts.req_free) state_in = ST_CHECK;
               else if (sts.req_bad) state_in = ST_FIN;
               else state_in = ST_WALK;
            end
         end
         ST_CHECK: begin
            state_in = sts.root_fits ? ST_DESC : ST_FIN;
         end
         ST_DESC: begin
            if (!sts.kid_fits || sts.kids_leaf) state_in = ST_MARK;
         end
         ST_WALK: begin
            if (sts.node_free) state_in = ST_MARK;
            else if (sts.node_right) state_in = ST_FIN;
         end
         ST_MARK: begin
            state_in = sts.at_root ? ST_FIN : ST_UP;
         end
         ST_UP: begin
            if (sts.parent_root) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_write = 1'b1;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (sts.req_free && sts.req_bad) begin
                  cmd.fail      = 1'b1;
                  cmd.fail_code = STATUS_BAD_PTR;
               end
            end
         end
         ST_CHECK: begin
            if (sts.root_fits) begin
               cmd.read_kids = 1'b1;
            end else begin
               cmd.fail      = 1'b1;
               cmd.fail_code = STATUS_NO_SPACE;
            end
         end
         ST_DESC: begin
            if (sts.kid_fits) cmd.descend = 1'b1;
         end
         ST_WALK: begin
            if (sts.node_free) begin
               cmd = '0;
            end else if (sts.node_right) begin
               // reached a right child or the root without finding the block
               cmd.fail      = 1'b1;
               cmd.fail_code = STATUS_BAD_PTR;
            end else begin
               cmd.walk_up = 1'b1;
            end
         end
         ST_MARK: begin
            cmd.mark = 1'b1;
         end
         ST_UP: begin
            cmd.up = 1'b1;
         end
         ST_FIN: begin
            if (sts.out_free) cmd.load_out = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- design/bat_dpath.sv -----
module bat_dpath
   import bat_pkg::*;
#(
   parameter int LEVELS          = BAT_LEVELS,
   parameter int MIN_BLOCK_POWER = BAT_MIN_BLOCK_POWER
) (
   input  logic            clock,
   input  logic            reset,
   input  bat_cmd_type     cmd,
   output bat_sts_type     sts,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   localparam int NODE_W    = LEVELS;
   localparam int MEM_DEPTH = 2 ** LEVELS;
   localparam int CODE_W    = $clog2(LEVELS + 1);
   localparam int OFF_W     = LEVELS - 1 + MIN_BLOCK_POWER;

   function automatic logic [NEED_W-1:0] need_class(input logic [15:0] bytes);
      logic [15:0]       less;
      logic [4:0]        bits;
      logic [NEED_W-1:0] t;
      less = (bytes == 16'd0) ? 16'd0 : bytes - 16'd1;
      bits = '0;
      for (int i = 0; i < 16; i++) begin
         if (less[i]) bits = 5'(i + 1);
      end
      t = NEED_W'(bits) + NEED_W'(1);
      if (t <= NEED_W'(MIN_BLOCK_POWER)) need_class = NEED_W'(1);
      else need_class = t - NEED_W'(MIN_BLOCK_POWER);
   endfunction

   function automatic logic fits(input logic [CODE_W-1:0] c, input logic [NEED_W-1:0] nc);
      fits = (c != '0) && (c <= CODE_W'(LEVELS)) && (NEED_W'(c) >= nc);
   endfunction

   logic [CODE_W-1:0] tree_ff [MEM_DEPTH];
   logic [CODE_W-1:0] rd_a_ff, rd_b_ff;

   logic              wr_en;
   logic [NODE_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
   logic [CODE_W-1:0] wr_data;

   logic [NODE_W-1:0] n_ff, n_in;
   logic [CODE_W-1:0] lvl_ff, lvl_in;
   logic [CODE_W-1:0] root_ff, root_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [OFF_W-1:0]  off_ff, off_in;
   logic [OFF_W-1:0]  half_ff, half_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic              op_ff, op_in;
   logic [CODE_W-1:0] cur_ff, cur_in;
   logic [CODE_W-1:0] res_cls_ff, res_cls_in;
   status_type        res_status_ff, res_status_in;
   rsp_payload_type   rsp_payload_ff, rsp_payload_in;

   logic [16+OFF_W-1:0] off_ext;
   logic [OFF_W-1:0]    off_pool;
   logic [NODE_W-1:0]   leaf_addr;
   logic [NODE_W-1:0]   kid_l, kid_r, pick, pick_l, pick_r;
   logic [NODE_W-1:0]   par, par_sib, n_sib;
   logic                fit_l, fit_r;
   logic [CODE_W-1:0]   mark_val, up_val, sib;
   logic [OFF_W+13-1:0] off_wide;
   logic [CODE_W+4-1:0] cls_wide, root_wide;
   logic                res_ok;

   // free offset checks and the leaf it points at
   assign off_ext   = {{OFF_W{1'b0}}, req_payload.free_offset};
   assign off_pool  = off_ext[OFF_W-1:0];
   assign leaf_addr = {1'b1, off_pool[OFF_W-1:MIN_BLOCK_POWER]};

   assign kid_l   = {n_ff[NODE_W-2:0], 1'b0};
   assign kid_r   = {n_ff[NODE_W-2:0], 1'b1};
   assign fit_l   = fits(rd_a_ff, need_ff);
   assign fit_r   = fits(rd_b_ff, need_ff);
   assign pick    = fit_l ? kid_l : kid_r;
   assign pick_l  = {pick[NODE_W-2:0], 1'b0};
   assign pick_r  = {pick[NODE_W-2:0], 1'b1};
   assign par     = {1'b0, n_ff[NODE_W-1:1]};
   assign par_sib = par ^ NODE_W'(1);
   assign n_sib   = n_ff ^ NODE_W'(1);
   assign sib     = rd_a_ff;

   assign mark_val = (op_ff == OP_FREE) ? lvl_ff : '0;

   // two fully free buddies merge into their parent
   always_comb begin
      if (op_ff == OP_FREE && cur_ff == lvl_ff && sib == lvl_ff) up_val = lvl_ff + CODE_W'(1);
      else up_val = (cur_ff > sib) ? cur_ff : sib;
   end

   always_comb begin
      wr_en   = cmd.clr_write | cmd.mark | cmd.up;
      wr_addr = n_ff;
      wr_data = lvl_ff;
      if (cmd.mark) wr_data = mark_val;
      if (cmd.up) begin
         wr_addr = par;
         wr_data = up_val;
      end
   end

   always_comb begin
      rd_addr_a = n_ff;
      rd_addr_b = n_ff;
      if (cmd.take) begin
         rd_addr_a = leaf_addr;
      end else if (cmd.read_kids) begin
         rd_addr_a = kid_l;
         rd_addr_b = kid_r;
      end else if (cmd.descend) begin
         rd_addr_a = pick_l;
         rd_addr_b = pick_r;
      end else if (cmd.walk_up) begin
         rd_addr_a = par;
      end else if (cmd.mark) begin
         rd_addr_a = n_sib;
      end else if (cmd.up) begin
         rd_addr_a = par_sib;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) tree_ff[wr_addr] <= wr_data;
      rd_a_ff <= tree_ff[rd_addr_a];
      rd_b_ff <= tree_ff[rd_addr_b];
   end

   always_comb begin
      n_in          = n_ff;
      lvl_in        = lvl_ff;
      root_in       = root_ff;
      off_in        = off_ff;
      half_in       = half_ff;
      need_in       = need_ff;
      op_in         = op_ff;
      cur_in        = cur_ff;
      res_cls_in    = res_cls_ff;
      res_status_in = res_status_ff;

      if (cmd.clr_write) begin
         n_in = n_ff + NODE_W'(1);
         // last node of a tree row, the next one starts a deeper row
         if ((n_ff & (n_ff + NODE_W'(1))) == '0) lvl_in = lvl_ff - CODE_W'(1);
      end
      if (cmd.take) begin
         op_in         = req_payload.op;
         need_in       = need_class(req_payload.request_bytes);
         half_in       = OFF_W'(1) << (OFF_W - 1);
         res_status_in = STATUS_OK;
         if (req_payload.op == OP_FREE) begin
            n_in   = leaf_addr;
            lvl_in = CODE_W'(1);
            off_in = off_pool;
         end else begin
            n_in   = NODE_W'(1);
            lvl_in = CODE_W'(LEVELS);
            off_in = '0;
         end
      end
      if (cmd.fail) res_status_in = cmd.fail_code;
      if (cmd.descend) begin
         n_in    = pick;
         lvl_in  = lvl_ff - CODE_W'(1);
         half_in = half_ff >> 1;
         if (!fit_l) off_in = off_ff + half_ff;
      end
      if (cmd.walk_up) begin
         n_in   = par;
         lvl_in = lvl_ff + CODE_W'(1);
      end
      if (cmd.mark) begin
         cur_in     = mark_val;
         res_cls_in = lvl_ff;
         if (n_ff == NODE_W'(1)) root_in = mark_val;
      end
      if (cmd.up) begin
         n_in   = par;
         cur_in = up_val;
         lvl_in = lvl_ff + CODE_W'(1);
         if (par == NODE_W'(1)) root_in = up_val;
      end
   end

   assign res_ok    = (res_status_ff == STATUS_OK);
   assign off_wide  = {13'd0, off_ff};
   assign cls_wide  = {4'd0, res_cls_ff};
   assign root_wide = {4'd0, root_ff};

   always_comb begin
      rsp_payload_in                    = rsp_payload_ff;
      rsp_valid_in                      = rsp_valid_ff & rsp_stall;
      if (cmd.load_out) begin
         rsp_valid_in                      = 1'b1;
         rsp_payload_in.status             = res_status_ff;
         rsp_payload_in.block_offset       = res_ok ? off_wide[12:0] : 13'd0;
         rsp_payload_in.block_class        = res_ok ? cls_wide[3:0] : 4'd0;
         rsp_payload_in.largest_free_class = root_wide[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= NODE_W'(1);
         lvl_ff       <= CODE_W'(LEVELS);
         root_ff      <= CODE_W'(LEVELS);
         rsp_valid_ff <= 1'b0;
      end else begin
         n_ff         <= n_in;
         lvl_ff       <= lvl_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff         <= off_in;
      half_ff        <= half_in;
      need_ff        <= need_in;
      op_ff          <= op_in;
      cur_ff         <= cur_in;
      res_cls_ff     <= res_cls_in;
      res_status_ff  <= res_status_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   always_comb begin
      sts             = '0;
      sts.clr_last    = &n_ff;
      sts.req_free    = (req_payload.op == OP_FREE);
      sts.req_bad     = ((off_ext >> OFF_W) != '0) || (off_pool[MIN_BLOCK_POWER-1:0] != '0);
      sts.root_fits   = fits(root_ff, need_ff);
      sts.kid_fits    = fit_l | fit_r;
      sts.kids_leaf   = n_ff[NODE_W-1] | n_ff[NODE_W-2];
      sts.node_free   = (rd_a_ff == '0);
      sts.node_right  = n_ff[0];
      sts.at_root     = (n_ff == NODE_W'(1));
      sts.parent_root = (par == NODE_W'(1));
      sts.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ----- design/buddy_allocator_tree.sv -----
// buddy allocator: an allocate descends one tree level a cycle, then walks back up one a cycle
// one transaction at a time: the next request is accepted only once the previous result is
// registered, and a stalled result holds the block; the size tree memory has a single write port
// and two read ports
// reset is synchronous; afterwards a clearing pass writes every tree node to rebuild the tree
// and no transaction is accepted until it ends
module buddy_allocator_tree
   import bat_pkg::*;
#(
   parameter int LEVELS          = BAT_LEVELS,
   parameter int MIN_BLOCK_POWER = BAT_MIN_BLOCK_POWER
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   bat_cmd_type cmd;
   bat_sts_type sts;

   bat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bat_dpath #(
      .LEVELS          (LEVELS),
      .MIN_BLOCK_POWER (MIN_BLOCK_POWER)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // datapath steps are mutually exclusive
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clr_write, cmd.take, cmd.read_kids, cmd.descend,
                cmd.walk_up, cmd.mark, cmd.up, cmd.load_out}))
      else $error("more than one datapath step in a cycle");

   // a finished transaction always shows up on the result side
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid)
      else $error("result load lost");

   // every successful block sits on a minimum block boundary
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == STATUS_OK)
         |-> (rsp_payload.block_offset[MIN_BLOCK_POWER-1:0] == '0))
      else $error("misaligned block offset");

endmodule

// ----- test/allocator_monitor.sv -----
module allocator_monitor
   import bat_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  rsp_payload_type rsp_payload,
   output int              pending,
   output int              failures
);

   localparam int NODES     = (1 << BAT_LEVELS) - 1;
   localparam int LEAF_BASE = (1 << (BAT_LEVELS - 1)) - 1;
   localparam int POOL      = 1 << (BAT_LEVELS - 1 + BAT_MIN_BLOCK_POWER);

   // largest free class under each node, in the block's tree order but indexed from zero
   logic [4:0]      size_code [NODES];
   rsp_payload_type due_results [$];

   function automatic bit fits(logic [4:0] code, int unsigned need);
      return code != 0 && code <= BAT_LEVELS &&
             (1 << (code + BAT_MIN_BLOCK_POWER - 1)) >= need;
   endfunction

   function automatic rsp_payload_type carve_block(logic [15:0] bytes);
      rsp_payload_type res;
      int unsigned     need;
      int unsigned     node;
      int unsigned     lvl;
      int unsigned     pos;
      int unsigned     left;
      int unsigned     pick;
      bit              settled;
      res  = '0;
      need = (bytes == 0) ? 1 : bytes;
      if (!fits(size_code[0], need)) begin
         res.status = STATUS_NO_SPACE;
      end else begin
         node    = 0;
         lvl     = 0;
         pos     = 0;
         settled = 1'b0;
         // left child wins whenever it fits
         while (!settled && node < LEAF_BASE) begin
            left = 2 * node + 1;
            pick = fits(size_code[left], need) ? left : left + 1;
            if (fits(size_code[pick], need)) begin
               pos  = (pos << 1) | (pick - left);
               node = pick;
               lvl++;
            end else begin
               settled = 1'b1;
            end
         end
         size_code[node] = '0;
         while (node > 0) begin
            node = (node - 1) / 2;
            size_code[node] = (size_code[2 * node + 1] > size_code[2 * node + 2]) ?
                              size_code[2 * node + 1] : size_code[2 * node + 2];
         end
         res.status       = STATUS_OK;
         res.block_offset = 13'(pos << (BAT_LEVELS - 1 - lvl + BAT_MIN_BLOCK_POWER));
         res.block_class  = 4'(BAT_LEVELS - lvl);
      end
      res.largest_free_class = size_code[0][3:0];
      return res;
   endfunction

   function automatic rsp_payload_type release_block(logic [15:0] offset);
      rsp_payload_type res;
      int unsigned     node;
      logic [4:0]      cls;
      logic [4:0]      lvl_code;
      logic [4:0]      lhs;
      logic [4:0]      rhs;
      bit              bad;
      res = '0;
      bad = (offset >= POOL) || (offset % (1 << BAT_MIN_BLOCK_POWER) != 0);
      cls = 5'd1;
      node = bad ? 0 : (offset >> BAT_MIN_BLOCK_POWER) + LEAF_BASE;
      // climb through left children until the allocated node turns up
      while (!bad && size_code[node] != 0) begin
         if (node % 2 == 0) begin
            bad = 1'b1;
         end else begin
            node = (node - 1) / 2;
            cls++;
         end
      end
      if (bad) begin
         res.status = STATUS_BAD_PTR;
      end else begin
         size_code[node] = cls;
         lvl_code = cls;
         while (node > 0) begin
            node = (node - 1) / 2;
            lhs  = size_code[2 * node + 1];
            rhs  = size_code[2 * node + 2];
            // two whole buddies merge into their parent
            if (lhs == lvl_code && rhs == lvl_code)
               size_code[node] = lvl_code + 5'd1;
            else
               size_code[node] = (lhs > rhs) ? lhs : rhs;
            lvl_code++;
         end
         res.status       = STATUS_OK;
         res.block_offset = offset[12:0];
         res.block_class  = cls[3:0];
      end
      res.largest_free_class = size_code[0][3:0];
      return res;
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         failures++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         for (int d = 0; d < BAT_LEVELS; d++)
            for (int n = (1 << d) - 1; n < (1 << (d + 1)) - 1; n++)
               size_code[n] = 5'(BAT_LEVELS - d);
         due_results.delete();
         pending  = 0;
         failures = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               failures++;
               $display("%0t: unexpected result, expected none, got %h", $time, rsp_payload);
            end else begin
               want = due_results.pop_front();
               check_field("status", want.status, rsp_payload.status);
               check_field("block_offset", want.block_offset, rsp_payload.block_offset);
               check_field("block_class", want.block_class, rsp_payload.block_class);
               check_field("largest_free_class", want.largest_free_class,
                           rsp_payload.largest_free_class);
            end
         end
         if (req_valid && !req_stall) begin
            if (req_payload.op == OP_ALLOC)
               due_results.push_back(carve_block(req_payload.request_bytes));
            else
               due_results.push_back(release_block(req_payload.free_offset));
         end
         pending = due_results.size();
      end
   end

endmodule

// ----- test/testbench.sv -----
module testbench;
   import bat_pkg::*;

   localparam int ITEMS          = 1500;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE         = 30;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;
   int              pending;
   int              failures;
   int              quiet;
   bit              calm;
   logic [12:0]     live_blocks [$];
   logic            sent_ops [$];

   buddy_allocator_tree DUT (.*);

   allocator_monitor monitor (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock)
      rsp_stall <= !calm && ($urandom_range(99) < 22);

   // blocks handed out, so that most frees name a real one
   always @(posedge clock) begin
      logic was_alloc;
      if (!reset) begin
         if (rsp_valid && !rsp_stall && sent_ops.size() != 0) begin
            was_alloc = (sent_ops.pop_front() == OP_ALLOC);
            if (was_alloc && rsp_payload.status == STATUS_OK)
               live_blocks.push_back(rsp_payload.block_offset);
         end
         if (req_valid && !req_stall)
            sent_ops.push_back(req_payload.op);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic req_payload_type alloc_req(logic [15:0] bytes);
      req_payload_type item;
      item.op            = OP_ALLOC;
      item.request_bytes = bytes;
      item.free_offset   = 16'($urandom);
      return item;
   endfunction

   function automatic req_payload_type free_req(logic [15:0] offset);
      req_payload_type item;
      item.op            = OP_FREE;
      item.request_bytes = 16'($urandom);
      item.free_offset   = offset;
      return item;
   endfunction

   task automatic send(req_payload_type item);
      if (!calm)
         while ($urandom_range(99) < 22) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (pending != 0);
   endtask

   initial begin
      req_payload_type item;
      int              pick;
      int              slot;
      int              span;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      calm        = 1'b0;
      repeat (3)
         @(negedge clock);
      reset <= 1'b0;

      // zero-byte and small requests, then ones that cannot fit
      send(alloc_req(16'd0));
      send(alloc_req(16'd17));
      send(alloc_req(16'd16));
      send(alloc_req(16'hFFFF));
      send(alloc_req(16'd8193));
      send(alloc_req(16'd8192));
      // misaligned, beyond the pool, inside a block
      send(free_req(16'd1));
      send(free_req(16'd8192));
      send(free_req(16'hFFFF));
      send(free_req(16'hFFF0));
      send(free_req(16'd48));
      // good free then a double free, then merge back to a whole pool
      send(free_req(16'd0));
      send(free_req(16'd0));
      send(free_req(16'd16));
      send(free_req(16'd32));
      // whole pool taken: root code zero refuses even the smallest request
      send(alloc_req(16'd8192));
      send(alloc_req(16'd0));
      send(free_req(16'd4096));
      send(free_req(16'd0));
      send(alloc_req(16'd4096));
      send(alloc_req(16'd4096));
      send(alloc_req(16'd1));
      send(free_req(16'd4096));
      send(free_req(16'd0));
      drain();
      live_blocks.delete();

      for (int n = 0; n < ITEMS; n++) begin
         calm = (n >= 500 && n < 800);
         if (n == 1000)
            drain();
         pick = $urandom_range(99);
         if (live_blocks.size() != 0 && (pick < 45 || live_blocks.size() > 48)) begin
            slot = $urandom_range(live_blocks.size() - 1);
            item = free_req({3'b000, live_blocks[slot]});
            live_blocks.delete(slot);
         end else if (pick < 88) begin
            // mostly small blocks, now and then up to twice the pool
            span = ($urandom_range(3) == 0) ? $urandom_range(14) : $urandom_range(8);
            item = alloc_req(16'($urandom_range(1 << span)));
         end else if (pick < 94) begin
            item = alloc_req(16'($urandom));
         end else if ($urandom_range(1) == 0) begin
            item = free_req(16'($urandom));
         end else begin
            item = free_req({3'b000, 9'($urandom), 4'b0000});
         end
         send(item);
      end
      calm = 1'b0;

      drain();
      repeat (SETTLE)
         @(negedge clock);
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/bat_pkg.sv
design/bat_ctrl.sv
design/bat_dpath.sv
design/buddy_allocator_tree.sv
test/allocator_monitor.sv
test/testbench.sv
